### rtl/pkhm_pkg.sv
// ----------------------------------------------------------------------------
// pkhm_pkg
// shared types and the key mixing functions of the pointer-keyed hash map
// ----------------------------------------------------------------------------
package pkhm_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 48;
  localparam int FILE_W  = 16;
  localparam int LINE_W  = 20;
  localparam int STAMP_W = 32;

  // one transaction after the front end, hash already applied
  typedef struct packed {
    op_t                op;
    logic               key_zero;
    logic [KEY_W-1:0]   key;
    logic [63:0]        hash;
    logic [SIZE_W-1:0]  alloc_size;
    logic [FILE_W-1:0]  file_id;
    logic [LINE_W-1:0]  line_no;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_NODE,
    ST_NODE_WAIT,
    ST_CHECK,
    ST_ACT,
    ST_ACT_WAIT,
    ST_DONE
  } st_t;

  function automatic logic [63:0] mix_a(input logic [63:0] k);
    logic [63:0] t;
    t = (~k) + (k << 21);
    t = t ^ (t >> 24);
    t = (t + (t << 3)) + (t << 8);
    return t;
  endfunction

  function automatic logic [63:0] mix_b(input logic [63:0] k);
    logic [63:0] t;
    t = k ^ (k >> 14);
    t = (t + (t << 2)) + (t << 4);
    t = t ^ (t >> 28);
    t = t + (t << 31);
    return t;
  endfunction

endpackage

### rtl/pointer_keyed_hash_map.sv
// ----------------------------------------------------------------------------
// pointer_keyed_hash_map
// chained hash table from 64-bit address keys to allocation records
// ----------------------------------------------------------------------------
// Queue-style ports on both sides. A front end hashes the key with mix_a and
// then mix_b, registering each result, and queues commands; a back end walks
// the bucket chain in memories with a registered read port, visiting each
// chain node through ST_NODE, ST_NODE_WAIT and ST_CHECK. Count and zero-key
// transactions skip the chain walk and go straight to ST_DONE. The back end
// takes the next command only after the previous result is popped and ST_DONE
// returns to ST_IDLE, while the front end hashes the next transaction in
// parallel. After reset a clearing pass writes NIL to every bucket head and
// links the free list before the first transaction is carried out.
module pointer_keyed_hash_map #(
  parameter int BUCKETS    = 1024,
  parameter int POOL_NODES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic [pkhm_pkg::KEY_W-1:0]     key,
  input  logic [pkhm_pkg::SIZE_W-1:0]    alloc_size,
  input  logic [pkhm_pkg::FILE_W-1:0]    file_id,
  input  logic [pkhm_pkg::LINE_W-1:0]    line_no,
  input  logic [pkhm_pkg::STAMP_W-1:0]   stamp,
  output logic                           empty,
  input  logic                           pop,
  output logic                           ok,
  output logic [pkhm_pkg::SIZE_W-1:0]    found_size,
  output logic [pkhm_pkg::FILE_W-1:0]    found_file,
  output logic [pkhm_pkg::LINE_W-1:0]    found_line,
  output logic [pkhm_pkg::STAMP_W-1:0]   found_stamp,
  output logic [10:0]                    entry_count
);
  import pkhm_pkg::*;

  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;

  pkhm_front u_front (
    .clk, .rst, .push, .full, .op, .key, .alloc_size, .file_id, .line_no,
    .stamp, .cmd_valid, .cmd, .cmd_take
  );

  pkhm_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .res_valid,
    .res_take(pop && res_valid), .ok, .found_size, .found_file, .found_line,
    .found_stamp, .entry_count
  );

  assign empty = !res_valid;

endmodule

### rtl/pkhm_front.sv
// ----------------------------------------------------------------------------
// pkhm_front
// accepts transactions, hashes the key in two stages, queues commands
// ----------------------------------------------------------------------------
module pkhm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     op,
  input  logic [pkhm_pkg::KEY_W-1:0]     key,
  input  logic [pkhm_pkg::SIZE_W-1:0]    alloc_size,
  input  logic [pkhm_pkg::FILE_W-1:0]    file_id,
  input  logic [pkhm_pkg::LINE_W-1:0]    line_no,
  input  logic [pkhm_pkg::STAMP_W-1:0]   stamp,
  output logic                           cmd_valid,
  output pkhm_pkg::cmd_t                 cmd,
  input  logic                           cmd_take
);
  import pkhm_pkg::*;

  cmd_t s1, s2, s1_mixed;
  logic s1_v, s2_v;
  cmd_t q [2];
  logic [1:0] q_cnt;
  logic q_wp, q_rp;
  logic s2_adv;

  // at most one transaction in the hash stages plus queue room reserved
  assign full = s1_v || s2_v || (q_cnt == 2'd2);
  assign s2_adv = s2_v && (q_cnt != 2'd2 || cmd_take);
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd = q[q_rp];

  always_comb begin
    s1_mixed = s1;
    s1_mixed.hash = mix_b(s1.hash);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      q_cnt <= '0;
      q_wp <= 1'b0;
      q_rp <= 1'b0;
    end else begin
      s1_v <= push && !full;
      if (s1_v) s2_v <= 1'b1;
      else if (s2_adv) s2_v <= 1'b0;
      if (s2_adv) q_wp <= ~q_wp;
      if (cmd_take) q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, s2_adv} - {1'b0, cmd_take};
    end
    if (push && !full) begin
      s1.op <= op_t'(op);
      s1.key_zero <= (key == '0);
      s1.key <= key;
      s1.hash <= mix_a(key);
      s1.alloc_size <= alloc_size;
      s1.file_id <= file_id;
      s1.line_no <= line_no;
      s1.stamp <= stamp;
    end
    if (s1_v) s2 <= s1_mixed;
    if (s2_adv) q[q_wp] <= s2;
  end

  assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("command queue overflow");
  assert property (@(posedge clk) disable iff (rst) cmd_take |-> cmd_valid)
    else $error("take from empty command queue");
  assert property (@(posedge clk) disable iff (rst) !(s1_v && s2_v))
    else $error("two transactions in hash stages");

endmodule

### rtl/pkhm_back.sv
// ----------------------------------------------------------------------------
// pkhm_back
// walks bucket chains in memory and carries out insert, lookup and remove
// ----------------------------------------------------------------------------
module pkhm_back #(
  parameter int BUCKETS    = 1024,
  parameter int POOL_NODES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  pkhm_pkg::cmd_t                 cmd,
  output logic                           cmd_take,
  output logic                           res_valid,
  input  logic                           res_take,
  output logic                           ok,
  output logic [pkhm_pkg::SIZE_W-1:0]    found_size,
  output logic [pkhm_pkg::FILE_W-1:0]    found_file,
  output logic [pkhm_pkg::LINE_W-1:0]    found_line,
  output logic [pkhm_pkg::STAMP_W-1:0]   found_stamp,
  output logic [10:0]                    entry_count
);
  import pkhm_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam int XW = ((BW > IW) ? BW : IW) + 1;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [FILE_W-1:0]  file;
    logic [LINE_W-1:0]  line;
    logic [STAMP_W-1:0] stamp;
  } rec_t;

  // memories
  logic [NW-1:0]    head_mem [BUCKETS];
  logic [NW-1:0]    next_mem [POOL_NODES];
  logic [KEY_W-1:0] key_mem  [POOL_NODES];
  rec_t             rec_mem  [POOL_NODES];

  st_t st, st_next;
  cmd_t c;
  logic [BW-1:0] bkt;
  logic [NW-1:0] cur, prev, free_head, nxt_rd, head_rd;
  logic [KEY_W-1:0] key_rd;
  rec_t rec_rd;
  logic [CW-1:0] live;
  logic [IW:0] steps;
  logic [XW-1:0] clr_idx;
  logic clearing;

  // memory control
  logic head_we, next_we, key_we, rec_we;
  logic [BW-1:0] head_wa;
  logic [NW-1:0] head_wd, next_wd;
  logic [IW-1:0] next_wa, node_wa;
  logic [IW-1:0] rd_node;
  logic res_hold;

  // freeing the removed node needs a second next write; done in ST_DONE
  logic free_pend;
  logic [NW-1:0] free_node, free_link;

  always_ff @(posedge clk) begin
    head_rd <= head_mem[bkt];
    nxt_rd <= next_mem[rd_node];
    key_rd <= key_mem[rd_node];
    rec_rd <= rec_mem[rd_node];
    if (head_we) head_mem[head_wa] <= head_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (key_we) key_mem[node_wa] <= c.key;
    if (rec_we) rec_mem[node_wa] <= '{c.alloc_size, c.file_id, c.line_no, c.stamp};
  end

  assign rd_node = ((st == ST_ACT || st == ST_ACT_WAIT) && c.op == OP_INSERT) ?
                   free_head[IW-1:0] : cur[IW-1:0];
  assign cmd_take = (st == ST_IDLE) && !clearing && cmd_valid;
  assign res_valid = res_hold;

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  logic hit;
  assign hit = (key_rd == c.key);

  always_comb begin
    st_next = st;
    head_we = 1'b0;
    head_wa = bkt;
    head_wd = cur;
    next_we = 1'b0;
    next_wa = cur[IW-1:0];
    next_wd = nxt_rd;
    key_we = 1'b0;
    rec_we = 1'b0;
    node_wa = cur[IW-1:0];
    if (clearing) begin
      head_we = 1'b1;
      head_wa = clr_idx[BW-1:0];
      head_wd = NIL;
      next_we = (clr_idx < XW'(POOL_NODES));
      next_wa = clr_idx[IW-1:0];
      next_wd = NW'(clr_idx) + NW'(1);
    end
    unique case (st)
      ST_IDLE: if (cmd_take) begin
        st_next = (cmd.op == OP_COUNT || cmd.key_zero) ? ST_DONE : ST_HEAD;
      end
      ST_HEAD: st_next = ST_HEAD_WAIT;
      ST_HEAD_WAIT: st_next = ST_NODE;
      ST_NODE: begin
        if (cur >= NIL || steps >= (IW+1)'(POOL_NODES)) st_next = ST_ACT;
        else st_next = ST_NODE_WAIT;
      end
      ST_NODE_WAIT: st_next = ST_CHECK;
      ST_CHECK: st_next = hit ? ST_ACT : ST_NODE;
      ST_ACT: st_next = ST_ACT_WAIT;
      ST_ACT_WAIT: begin
        st_next = ST_DONE;
        if (c.op == OP_INSERT) begin
          if (cur < NIL) begin
            rec_we = 1'b1;
          end else if (free_head < NIL) begin
            node_wa = free_head[IW-1:0];
            key_we = 1'b1;
            rec_we = 1'b1;
            next_we = 1'b1;
            next_wa = free_head[IW-1:0];
            next_wd = head_rd;
            head_we = 1'b1;
            head_wd = free_head;
          end
        end else if (c.op == OP_REMOVE && cur < NIL) begin
          if (prev < NIL) begin
            next_we = 1'b1;
            next_wa = prev[IW-1:0];
            next_wd = nxt_rd;
          end else begin
            head_we = 1'b1;
            head_wd = nxt_rd;
          end
        end
      end
      ST_DONE: if (!res_hold) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
    if (free_pend) begin
      next_we = 1'b1;
      next_wa = free_node[IW-1:0];
      next_wd = free_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      free_head <= '0;
      live <= '0;
      res_hold <= 1'b0;
      free_pend <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx >= XW'(BUCKETS - 1) && clr_idx >= XW'(POOL_NODES - 1))
          clearing <= 1'b0;
      end
      if (res_take) res_hold <= 1'b0;
      if (free_pend) free_pend <= 1'b0;
      unique case (st)
        ST_IDLE: if (cmd_take) begin
          c <= cmd;
          bkt <= cmd.hash[BW-1:0];
          prev <= NIL;
          steps <= '0;
          ok <= (cmd.op == OP_COUNT);
          found_size <= '0;
          found_file <= '0;
          found_line <= '0;
          found_stamp <= '0;
        end
        ST_HEAD_WAIT: cur <= head_rd;
        ST_NODE: if (cur >= NIL || steps >= (IW+1)'(POOL_NODES)) cur <= NIL;
        ST_CHECK: if (!hit) begin
          prev <= cur;
          cur <= (cur < NIL) ? nxt_rd : NIL;
          steps <= steps + 1'b1;
        end
        ST_ACT: begin
          if (c.op == OP_LOOKUP && cur < NIL) begin
            ok <= 1'b1;
            found_size <= rec_rd.size;
            found_file <= rec_rd.file;
            found_line <= rec_rd.line;
            found_stamp <= rec_rd.stamp;
          end
        end
        ST_ACT_WAIT: begin
          if (c.op == OP_INSERT) begin
            if (cur < NIL) ok <= 1'b1;
            else if (free_head < NIL) begin
              ok <= 1'b1;
              free_head <= nxt_rd;
              live <= live + 1'b1;
            end
          end else if (c.op == OP_REMOVE && cur < NIL) begin
            ok <= 1'b1;
            free_pend <= 1'b1;
            free_node <= cur;
            free_link <= free_head;
            free_head <= cur;
            if (live != '0) live <= live - 1'b1;
          end
          res_hold <= 1'b1;
        end
        default: ;
      endcase
      if (st == ST_IDLE && cmd_take && (cmd.op == OP_COUNT || cmd.key_zero))
        res_hold <= 1'b1;
    end
  end

  assign entry_count = 11'(live);

  assert property (@(posedge clk) disable iff (rst) live <= CW'(POOL_NODES))
    else $error("live count beyond pool");
  assert property (@(posedge clk) disable iff (rst) cmd_take |-> !res_hold)
    else $error("command taken while result pending");
  assert property (@(posedge clk) disable iff (rst) clearing |-> st == ST_IDLE)
    else $error("work during clearing pass");

endmodule
